// ----- rtl/dhla_pkg.sv -----
// ----------------------------------------------------------------------------
// dhla_pkg
// shared widths, codes, register map and types of the lease allocator
// ----------------------------------------------------------------------------
package dhla_pkg;

   localparam int DEFAULT_POOL_SLOTS = 64;

   localparam int OP_W    = 2;
   localparam int MAC_W   = 48;
   localparam int XID_W   = 32;
   localparam int IP_W    = 32;
   localparam int TIME_W  = 32;
   localparam int KIND_W  = 3;
   localparam int LEASE_W = 31;
   localparam int POOL_W  = 7;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [OP_W-1:0] OP_DISCOVER = 2'd0;
   localparam logic [OP_W-1:0] OP_REQUEST  = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE  = 2'd2;

   localparam logic [KIND_W-1:0] KIND_OFFER     = 3'd0;
   localparam logic [KIND_W-1:0] KIND_ACK       = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NAK       = 3'd2;
   localparam logic [KIND_W-1:0] KIND_EXHAUSTED = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RELEASED  = 3'd4;
   localparam logic [KIND_W-1:0] KIND_NOT_FOUND = 3'd5;

   localparam logic [1:0] REG_SERVER_ID     = 2'd0;
   localparam logic [1:0] REG_LEASE_SECONDS = 2'd1;
   localparam logic [1:0] REG_POOL_BASE     = 2'd2;
   localparam logic [1:0] REG_POOL_COUNT    = 2'd3;

   localparam logic [IP_W-1:0]    RESET_SERVER_ID     = 32'd0;
   localparam logic [LEASE_W-1:0] RESET_LEASE_SECONDS = 31'd3600;
   localparam logic [IP_W-1:0]    RESET_POOL_BASE     = 32'd0;
   localparam logic [POOL_W-1:0]  RESET_POOL_COUNT    = 7'd64;

   typedef struct packed {
      logic [IP_W-1:0]    server_id;
      logic [LEASE_W-1:0] lease_seconds;
      logic [IP_W-1:0]    pool_base;
      logic [POOL_W-1:0]  pool_count;
   } cfg_type;

   typedef struct packed {
      logic              valid;
      logic [MAC_W-1:0]  owner;
      logic [TIME_W-1:0] start;
   } ent_type;

   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [MAC_W-1:0]  client_mac;
      logic [XID_W-1:0]  transaction_id;
      logic [IP_W-1:0]   requested_ip;
      logic              has_requested_ip;
      logic [IP_W-1:0]   requested_server;
      logic              has_server_id;
      logic [TIME_W-1:0] now_seconds;
   } req_type;

   typedef struct packed {
      logic [KIND_W-1:0]  reply_kind;
      logic [XID_W-1:0]   reply_xid;
      logic [MAC_W-1:0]   reply_mac;
      logic [IP_W-1:0]    reply_ip;
      logic [LEASE_W-1:0] reply_lease;
   } rsp_type;

endpackage

// ----- rtl/dhla_if.sv -----
// ----------------------------------------------------------------------------
// dhla_if
// request and response channel interfaces with valid/ready handshake
// ----------------------------------------------------------------------------
interface dhla_req_if;
   import dhla_pkg::*;

   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [MAC_W-1:0]  client_mac;
   logic [XID_W-1:0]  transaction_id;
   logic [IP_W-1:0]   requested_ip;
   logic              has_requested_ip;
   logic [IP_W-1:0]   requested_server;
   logic              has_server_id;
   logic [TIME_W-1:0] now_seconds;

   modport source (
      output valid, op, client_mac, transaction_id, requested_ip, has_requested_ip,
             requested_server, has_server_id, now_seconds,
      input  ready
   );
   modport sink (
      input  valid, op, client_mac, transaction_id, requested_ip, has_requested_ip,
             requested_server, has_server_id, now_seconds,
      output ready
   );
endinterface

interface dhla_rsp_if;
   import dhla_pkg::*;

   logic               valid;
   logic               ready;
   logic [KIND_W-1:0]  reply_kind;
   logic [XID_W-1:0]   reply_xid;
   logic [MAC_W-1:0]   reply_mac;
   logic [IP_W-1:0]    reply_ip;
   logic [LEASE_W-1:0] reply_lease;

   modport source (
      output valid, reply_kind, reply_xid, reply_mac, reply_ip, reply_lease,
      input  ready
   );
   modport sink (
      input  valid, reply_kind, reply_xid, reply_mac, reply_ip, reply_lease,
      output ready
   );
endinterface

// ----- rtl/dhcp_lease_allocator_unit.sv -----
// ----------------------------------------------------------------------------
// dhcp_lease_allocator_unit
// lease table allocator for a contiguous address pool
//
// Requests (discover, request, release) enter on req_bus with valid/ready;
// every discover, request and release gives one reply on rsp_bus, an unused
// op code is taken and dropped. Configuration is written over the csr_ apb
// port only while no request is in flight; the user must keep to this, the
// block itself does not enforce it. Each request walks the lease table
// memory one slot per cycle through its single read port: release scans for
// the owner's slot, request checks the asked slot, clears the owner's old
// leases and writes the new one, a request rejected on its options skips the
// table, discover scans and purges expired leases if any. One request is in
// work at a time. After reset the table is cleared slot by slot, with
// req_bus.ready low; csr writes are taken throughout. A finished reply waits
// in an output register while rsp_bus.ready is low, and the next request is
// accepted meanwhile; its reply waits until the register frees up.
// ----------------------------------------------------------------------------
module dhcp_lease_allocator_unit #(
   parameter int POOL_SLOTS = dhla_pkg::DEFAULT_POOL_SLOTS
) (
   input  logic                            clock,
   input  logic                            reset,
   dhla_req_if.sink                        req_bus,
   dhla_rsp_if.source                      rsp_bus,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [dhla_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [dhla_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [dhla_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);
   import dhla_pkg::*;

   localparam int IDX_W = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   cfg_type          cfg;
   logic             mem_rd_en;
   logic [IDX_W-1:0] mem_rd_addr;
   ent_type          mem_rd_data;
   logic             mem_wr_en;
   logic [IDX_W-1:0] mem_wr_addr;
   ent_type          mem_wr_data;

   dhla_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   dhla_lease_ram #(
      .SLOTS (POOL_SLOTS)
   ) u_ram (
      .clock   (clock),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data)
   );

   dhla_engine #(
      .POOL_SLOTS (POOL_SLOTS)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data)
   );

endmodule

// ----- rtl/dhla_csr.sv -----
// ----------------------------------------------------------------------------
// dhla_csr
// apb register file: server id, lease time, pool base and pool size
// ----------------------------------------------------------------------------
module dhla_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [dhla_pkg::CSR_ADDR_W-1:0]   paddr,
   input  logic [dhla_pkg::CSR_DATA_W-1:0]   pwdata,
   output logic [dhla_pkg::CSR_DATA_W-1:0]   prdata,
   output logic                              pready,
   output dhla_pkg::cfg_type                 cfg
);
   import dhla_pkg::*;

   logic [IP_W-1:0]    server_id_ff, server_id_in;
   logic [LEASE_W-1:0] lease_ff, lease_in;
   logic [IP_W-1:0]    pool_base_ff, pool_base_in;
   logic [POOL_W-1:0]  pool_count_ff, pool_count_in;
   logic               wr_hit;
   logic [1:0]         reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[3:2];
   assign wr_hit  = psel && penable && pwrite && pready;

   always_comb begin
      server_id_in  = server_id_ff;
      lease_in      = lease_ff;
      pool_base_in  = pool_base_ff;
      pool_count_in = pool_count_ff;
      if (wr_hit) begin
         unique case (reg_idx)
            REG_SERVER_ID:     server_id_in  = pwdata;
            REG_LEASE_SECONDS: lease_in      = pwdata[LEASE_W-1:0];
            REG_POOL_BASE:     pool_base_in  = pwdata;
            REG_POOL_COUNT:    pool_count_in = pwdata[POOL_W-1:0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_SERVER_ID:     prdata = server_id_ff;
         REG_LEASE_SECONDS: prdata = {1'b0, lease_ff};
         REG_POOL_BASE:     prdata = pool_base_ff;
         REG_POOL_COUNT:    prdata = {{(CSR_DATA_W-POOL_W){1'b0}}, pool_count_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         server_id_ff  <= RESET_SERVER_ID;
         lease_ff      <= RESET_LEASE_SECONDS;
         pool_base_ff  <= RESET_POOL_BASE;
         pool_count_ff <= RESET_POOL_COUNT;
      end else begin
         server_id_ff  <= server_id_in;
         lease_ff      <= lease_in;
         pool_base_ff  <= pool_base_in;
         pool_count_ff <= pool_count_in;
      end
   end

   assign cfg.server_id     = server_id_ff;
   assign cfg.lease_seconds = lease_ff;
   assign cfg.pool_base     = pool_base_ff;
   assign cfg.pool_count    = pool_count_ff;

endmodule

// ----- rtl/dhla_lease_ram.sv -----
// ----------------------------------------------------------------------------
// dhla_lease_ram
// lease table memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module dhla_lease_ram #(
   parameter  int SLOTS = dhla_pkg::DEFAULT_POOL_SLOTS,
   localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [IDX_W-1:0]  rd_addr,
   output dhla_pkg::ent_type rd_data,
   input  logic              wr_en,
   input  logic [IDX_W-1:0]  wr_addr,
   input  dhla_pkg::ent_type wr_data
);
   import dhla_pkg::*;

   ent_type ram_ff [SLOTS];
   ent_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/dhla_engine.sv -----
// ----------------------------------------------------------------------------
// dhla_engine
// request sequencer: scans the lease table, updates it and forms the reply
// ----------------------------------------------------------------------------
module dhla_engine #(
   parameter  int POOL_SLOTS = dhla_pkg::DEFAULT_POOL_SLOTS,
   localparam int IDX_W      = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  dhla_pkg::cfg_type cfg,
   dhla_req_if.sink          req_bus,
   dhla_rsp_if.source        rsp_bus,
   output logic              mem_rd_en,
   output logic [IDX_W-1:0]  mem_rd_addr,
   input  dhla_pkg::ent_type mem_rd_data,
   output logic              mem_wr_en,
   output logic [IDX_W-1:0]  mem_wr_addr,
   output dhla_pkg::ent_type mem_wr_data
);
   import dhla_pkg::*;

   localparam int CNT_W = $clog2(POOL_SLOTS + 1);
   localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(POOL_SLOTS);
   localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(POOL_SLOTS - 1);

   localparam logic [3:0] S_CLEAR      = 4'd0;
   localparam logic [3:0] S_IDLE       = 4'd1;
   localparam logic [3:0] S_DISC_SCAN  = 4'd2;
   localparam logic [3:0] S_DISC_PURGE = 4'd3;
   localparam logic [3:0] S_REQ_READ   = 4'd4;
   localparam logic [3:0] S_REQ_CHECK  = 4'd5;
   localparam logic [3:0] S_REQ_SCAN   = 4'd6;
   localparam logic [3:0] S_REQ_WRITE  = 4'd7;
   localparam logic [3:0] S_REL_SCAN   = 4'd8;
   localparam logic [3:0] S_FINISH     = 4'd9;

   logic [3:0]         state_ff, state_in;
   logic [CNT_W-1:0]   scan_ff, scan_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]   rd_idx_ff, rd_idx_in;
   logic               rsp_valid_ff, rsp_valid_in;

   req_type            item_ff, item_in;
   logic [IDX_W-1:0]   req_idx_ff, req_idx_in;
   logic               owner_seen_ff, owner_seen_in;
   logic               free_found_ff, free_found_in;
   logic [IDX_W-1:0]   free_idx_ff, free_idx_in;
   logic               any_exp_ff, any_exp_in;
   logic [KIND_W-1:0]  res_kind_ff, res_kind_in;
   logic [IP_W-1:0]    res_ip_ff, res_ip_in;
   logic [LEASE_W-1:0] res_lease_ff, res_lease_in;
   rsp_type            rsp_ff, rsp_in;

   ent_type            ent;
   logic [TIME_W:0]    end_time;
   logic               ent_exp;
   logic               ent_mac;
   logic [IP_W-1:0]    pool_lim;
   logic               slot_in_pool;
   logic               last_slot;
   logic               scan_state;
   logic [IP_W-1:0]    pool_off;
   logic               req_ok;

   assign ent          = mem_rd_data;
   assign end_time     = {1'b0, ent.start} + {2'b0, cfg.lease_seconds};
   assign ent_exp      = ent.valid && ({1'b0, item_ff.now_seconds} >= end_time);
   assign ent_mac      = ent.valid && (ent.owner == item_ff.client_mac);
   assign pool_lim     = (32'(cfg.pool_count) > 32'(POOL_SLOTS)) ?
                         32'(POOL_SLOTS) : 32'(cfg.pool_count);
   assign slot_in_pool = 32'(rd_idx_ff) < pool_lim;
   assign last_slot    = rd_idx_ff == LAST_IDX;
   assign scan_state   = (state_ff == S_DISC_SCAN) || (state_ff == S_DISC_PURGE) ||
                         (state_ff == S_REQ_SCAN) || (state_ff == S_REL_SCAN);
   assign pool_off     = req_bus.requested_ip - cfg.pool_base;
   assign req_ok       = req_bus.has_server_id && req_bus.has_requested_ip &&
                         (req_bus.requested_server == cfg.server_id) &&
                         (pool_off < pool_lim);

   always_comb begin
      state_in      = state_ff;
      scan_in       = scan_ff;
      rd_pend_in    = 1'b0;
      rd_idx_in     = rd_idx_ff;
      rsp_valid_in  = rsp_valid_ff;
      item_in       = item_ff;
      req_idx_in    = req_idx_ff;
      owner_seen_in = owner_seen_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      any_exp_in    = any_exp_ff;
      res_kind_in   = res_kind_ff;
      res_ip_in     = res_ip_ff;
      res_lease_in  = res_lease_ff;
      rsp_in        = rsp_ff;
      req_bus.ready = 1'b0;
      mem_rd_en     = 1'b0;
      mem_rd_addr   = scan_ff[IDX_W-1:0];
      mem_wr_en     = 1'b0;
      mem_wr_addr   = rd_idx_ff;
      mem_wr_data   = '{valid: 1'b0, owner: ent.owner, start: ent.start};

      if (rsp_valid_ff && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end

      // sweep read issue, data comes back in the next cycle
      if (scan_state && (scan_ff < SLOTS_CNT)) begin
         mem_rd_en  = 1'b1;
         rd_pend_in = 1'b1;
         rd_idx_in  = scan_ff[IDX_W-1:0];
         scan_in    = scan_ff + 1'b1;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = scan_ff[IDX_W-1:0];
            mem_wr_data = '0;
            scan_in     = scan_ff + 1'b1;
            if (scan_ff[IDX_W-1:0] == LAST_IDX) begin
               scan_in  = '0;
               state_in = S_IDLE;
            end
         end

         S_IDLE: begin
            req_bus.ready = 1'b1;
            scan_in       = '0;
            owner_seen_in = 1'b0;
            free_found_in = 1'b0;
            any_exp_in    = 1'b0;
            if (req_bus.valid) begin
               item_in.op               = req_bus.op;
               item_in.client_mac       = req_bus.client_mac;
               item_in.transaction_id   = req_bus.transaction_id;
               item_in.requested_ip     = req_bus.requested_ip;
               item_in.has_requested_ip = req_bus.has_requested_ip;
               item_in.requested_server = req_bus.requested_server;
               item_in.has_server_id    = req_bus.has_server_id;
               item_in.now_seconds      = req_bus.now_seconds;
               req_idx_in               = pool_off[IDX_W-1:0];
               unique case (req_bus.op)
                  OP_DISCOVER: state_in = S_DISC_SCAN;
                  OP_REQUEST: begin
                     if (req_ok) begin
                        state_in = S_REQ_READ;
                     end else begin
                        res_kind_in  = KIND_NAK;
                        res_ip_in    = '0;
                        res_lease_in = '0;
                        state_in     = S_FINISH;
                     end
                  end
                  OP_RELEASE:  state_in = S_REL_SCAN;
                  default:     state_in = S_IDLE;
               endcase
            end
         end

         S_DISC_SCAN: begin
            if (rd_pend_ff) begin
               if (ent_exp) begin
                  any_exp_in = 1'b1;
               end
               if (!free_found_ff && slot_in_pool && (!ent.valid || ent_exp)) begin
                  free_found_in = 1'b1;
                  free_idx_in   = rd_idx_ff;
               end
               if (ent_mac && !owner_seen_ff) begin
                  owner_seen_in = 1'b1;
               end
               if (ent_mac && !owner_seen_ff && !ent_exp) begin
                  res_kind_in  = KIND_OFFER;
                  res_ip_in    = cfg.pool_base + 32'(rd_idx_ff);
                  res_lease_in = cfg.lease_seconds;
                  state_in     = S_FINISH;
               end else if (last_slot) begin
                  if (free_found_in) begin
                     res_kind_in  = KIND_OFFER;
                     res_ip_in    = cfg.pool_base + 32'(free_idx_in);
                     res_lease_in = cfg.lease_seconds;
                  end else begin
                     res_kind_in  = KIND_EXHAUSTED;
                     res_ip_in    = '0;
                     res_lease_in = '0;
                  end
                  scan_in  = '0;
                  state_in = any_exp_in ? S_DISC_PURGE : S_FINISH;
               end
            end
         end

         S_DISC_PURGE: begin
            if (rd_pend_ff) begin
               if (ent_exp) begin
                  mem_wr_en = 1'b1;
               end
               if (last_slot) begin
                  state_in = S_FINISH;
               end
            end
         end

         S_REQ_READ: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = req_idx_ff;
            rd_pend_in  = 1'b1;
            rd_idx_in   = req_idx_ff;
            state_in    = S_REQ_CHECK;
         end

         S_REQ_CHECK: begin
            if (ent.valid && (ent.owner != item_ff.client_mac) && !ent_exp) begin
               res_kind_in  = KIND_NAK;
               res_ip_in    = '0;
               res_lease_in = '0;
               state_in     = S_FINISH;
            end else begin
               scan_in  = '0;
               state_in = S_REQ_SCAN;
            end
         end

         S_REQ_SCAN: begin
            if (rd_pend_ff) begin
               if (ent_mac) begin
                  mem_wr_en = 1'b1;
               end
               if (last_slot) begin
                  state_in = S_REQ_WRITE;
               end
            end
         end

         S_REQ_WRITE: begin
            mem_wr_en    = 1'b1;
            mem_wr_addr  = req_idx_ff;
            mem_wr_data  = '{valid: 1'b1, owner: item_ff.client_mac,
                             start: item_ff.now_seconds};
            res_kind_in  = KIND_ACK;
            res_ip_in    = item_ff.requested_ip;
            res_lease_in = cfg.lease_seconds;
            state_in     = S_FINISH;
         end

         S_REL_SCAN: begin
            if (rd_pend_ff) begin
               if (ent_mac) begin
                  mem_wr_en    = 1'b1;
                  res_kind_in  = KIND_RELEASED;
                  res_ip_in    = '0;
                  res_lease_in = '0;
                  state_in     = S_FINISH;
               end else if (last_slot) begin
                  res_kind_in  = KIND_NOT_FOUND;
                  res_ip_in    = '0;
                  res_lease_in = '0;
                  state_in     = S_FINISH;
               end
            end
         end

         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in       = 1'b1;
               rsp_in.reply_kind  = res_kind_ff;
               rsp_in.reply_xid   = item_ff.transaction_id;
               rsp_in.reply_mac   = item_ff.client_mac;
               rsp_in.reply_ip    = res_ip_ff;
               rsp_in.reply_lease = res_lease_ff;
               state_in           = S_IDLE;
            end
         end

         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         scan_ff      <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         scan_ff      <= scan_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff     <= rd_idx_in;
      item_ff       <= item_in;
      req_idx_ff    <= req_idx_in;
      owner_seen_ff <= owner_seen_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      any_exp_ff    <= any_exp_in;
      res_kind_ff   <= res_kind_in;
      res_ip_ff     <= res_ip_in;
      res_lease_ff  <= res_lease_in;
      rsp_ff        <= rsp_in;
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.reply_kind  = rsp_ff.reply_kind;
   assign rsp_bus.reply_xid   = rsp_ff.reply_xid;
   assign rsp_bus.reply_mac   = rsp_ff.reply_mac;
   assign rsp_bus.reply_ip    = rsp_ff.reply_ip;
   assign rsp_bus.reply_lease = rsp_ff.reply_lease;

endmodule
